@@ hdl/mvr_pkg.sv @@
// Shared types and constants for the motion vector reconstruction block.
`timescale 1ns / 1ps

package mvr_pkg;

    localparam int MV_WIDTH        = 14;
    localparam int CODE_WIDTH      = 6;
    localparam int RESID_WIDTH     = 8;
    localparam int RANGE_WIDTH     = 4;
    localparam int DELTA_WIDTH     = 13;
    localparam int SUM_WIDTH       = 15;
    localparam int MAX_RANGE_BITS  = 8;
    localparam int CODE_LIMIT      = 16;
    localparam int NUM_PRED        = 8;
    localparam int PRED_IDX_WIDTH  = 3;
    localparam int APB_ADDR_WIDTH  = 5;
    localparam int APB_DATA_WIDTH  = 32;

    typedef enum logic [2:0] {
        REG_FWD_H_RANGE = 3'd0,
        REG_FWD_V_RANGE = 3'd1,
        REG_BWD_H_RANGE = 3'd2,
        REG_BWD_V_RANGE = 3'd3,
        REG_FULL_PEL    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [3:0][RANGE_WIDTH-1:0] range_bits;
        logic                        full_pel;
    } t_cfg;

    typedef struct packed {
        logic                          direction;
        logic                          vector_sel;
        logic                          component;
        logic signed [CODE_WIDTH-1:0]  mv_code;
        logic [RESID_WIDTH-1:0]        motion_residual;
        logic                          halve_vertical;
        logic                          copy_to_second;
    } t_item;

endpackage

@@ hdl/mvr_cfg.sv @@
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module mvr_cfg
    import mvr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_WIDTH-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_FWD_H_RANGE: n_cfg.range_bits[0] = pwdata[RANGE_WIDTH-1:0];
                REG_FWD_V_RANGE: n_cfg.range_bits[1] = pwdata[RANGE_WIDTH-1:0];
                REG_BWD_H_RANGE: n_cfg.range_bits[2] = pwdata[RANGE_WIDTH-1:0];
                REG_BWD_V_RANGE: n_cfg.range_bits[3] = pwdata[RANGE_WIDTH-1:0];
                REG_FULL_PEL:    n_cfg.full_pel      = pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FWD_H_RANGE: prdata = APB_DATA_WIDTH'(r_cfg.range_bits[0]);
            REG_FWD_V_RANGE: prdata = APB_DATA_WIDTH'(r_cfg.range_bits[1]);
            REG_BWD_H_RANGE: prdata = APB_DATA_WIDTH'(r_cfg.range_bits[2]);
            REG_BWD_V_RANGE: prdata = APB_DATA_WIDTH'(r_cfg.range_bits[3]);
            REG_FULL_PEL:    prdata = APB_DATA_WIDTH'(r_cfg.full_pel);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ hdl/mvr_calc.sv @@
// Combinational update of one vector component from its predictor.
`timescale 1ns / 1ps

module mvr_calc
    import mvr_pkg::*;
(
    input  t_item                       i_item,
    input  t_cfg                        i_cfg,
    input  logic signed [MV_WIDTH-1:0]  i_pred,
    output logic signed [MV_WIDTH-1:0]  o_value
);

    logic [RANGE_WIDTH-1:0]        w_r_raw;
    logic [RANGE_WIDTH-1:0]        w_r;
    logic [RANGE_WIDTH-1:0]        w_top;
    logic                          w_scale;
    logic signed [MV_WIDTH-1:0]    w_half1;
    logic signed [MV_WIDTH-1:0]    w_half2;
    logic signed [CODE_WIDTH-1:0]  w_code;
    logic [4:0]                    w_mag;
    logic [3:0]                    w_mag_m1;
    logic [RESID_WIDTH-1:0]        w_mask;
    logic [DELTA_WIDTH-1:0]        w_delta;
    logic [SUM_WIDTH-1:0]          w_sum;
    logic [DELTA_WIDTH-1:0]        w_wrap;
    logic signed [MV_WIDTH-1:0]    w_new;
    logic signed [MV_WIDTH-1:0]    w_dbl1;

    assign w_r_raw = i_cfg.range_bits[{i_item.direction, i_item.component}];
    assign w_r     = (w_r_raw > RANGE_WIDTH'(MAX_RANGE_BITS))
                     ? RANGE_WIDTH'(MAX_RANGE_BITS) : w_r_raw;
    assign w_top   = RANGE_WIDTH'(4) + w_r;
    assign w_scale = i_item.halve_vertical && i_item.component;

    assign w_half1 = w_scale ? (i_pred >>> 1) : i_pred;
    assign w_half2 = i_cfg.full_pel ? (w_half1 >>> 1) : w_half1;

    always_comb begin
        if (i_item.mv_code > CODE_WIDTH'(CODE_LIMIT)) begin
            w_code = CODE_WIDTH'(CODE_LIMIT);
        end else if (i_item.mv_code < -CODE_WIDTH'(CODE_LIMIT)) begin
            w_code = -CODE_WIDTH'(CODE_LIMIT);
        end else begin
            w_code = i_item.mv_code;
        end
    end

    assign w_mag    = w_code[CODE_WIDTH-1] ? 5'(-w_code) : 5'(w_code);
    assign w_mag_m1 = 4'(w_mag - 5'd1);
    assign w_mask   = ~(8'hFF << w_r);
    assign w_delta  = (DELTA_WIDTH'(w_mag_m1) << w_r)
                      + DELTA_WIDTH'(i_item.motion_residual & w_mask)
                      + DELTA_WIDTH'(1);
    assign w_sum    = w_code[CODE_WIDTH-1]
                      ? SUM_WIDTH'(w_half2) - SUM_WIDTH'(w_delta)
                      : SUM_WIDTH'(w_half2) + SUM_WIDTH'(w_delta);

    // Wrapping into the range keeps the low bits and repeats the top range bit.
    always_comb begin
        for (int i = 0; i < DELTA_WIDTH; i++) begin
            w_wrap[i] = (RANGE_WIDTH'(i) <= w_top) ? w_sum[i] : w_sum[w_top];
        end
    end

    assign w_new   = (w_code == '0) ? w_half2 : {w_wrap[DELTA_WIDTH-1], w_wrap};
    assign w_dbl1  = i_cfg.full_pel ? (w_new <<< 1) : w_new;
    assign o_value = w_scale ? (w_dbl1 <<< 1) : w_dbl1;

endmodule

@@ hdl/motion_vector_reconstruct.sv @@
// Top level of the motion vector reconstruction block.
//
// Each input item carries one decoded motion code and residual for one
// component of one vector. The block keeps eight predictors, selected by
// direction, vector and component, and returns the rebuilt component as one
// result item. Range bits per direction and component and the full-pel mode
// are set through the APB-style port; change them only while the block idles.
// An accepted item is held in an input register, updated by a short add and
// wrap, and moved into the output register, where its result is offered, once
// that register is empty or being drained. One item per cycle is taken
// as long as results are drained; the predictor write back lands on the same
// edge as the result register, so the next item always sees the updated
// predictor. When the receiver stalls the result waits in the output register
// and one more item waits in the input register before s_axis_tready falls.
// Reset clears all predictors, the configuration registers and both valid flags.
`timescale 1ns / 1ps

module motion_vector_reconstruct
    import mvr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // mv_code [5:0], motion_residual [13:6], halve_vertical [14],
    // copy_to_second [15]
    input  logic [15:0]               s_axis_tdata,
    // direction [0], vector_sel [1], component [2]
    input  logic [2:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // vector_value [13:0], zeros [15:14]
    output logic [15:0]               m_axis_tdata
);

    t_cfg                          w_cfg;
    t_item                         w_in_item;
    logic                          w_accept;
    logic                          w_adv;
    logic                          r_in_valid;
    logic                          n_in_valid;
    t_item                         r_in;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic signed [MV_WIDTH-1:0]    r_out;
    logic signed [MV_WIDTH-1:0]    r_pred [NUM_PRED];
    logic signed [MV_WIDTH-1:0]    w_value;
    logic [PRED_IDX_WIDTH-1:0]     w_idx;
    logic [PRED_IDX_WIDTH-1:0]     w_copy_idx;

    mvr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_in_item.direction       = s_axis_tuser[0];
    assign w_in_item.vector_sel      = s_axis_tuser[1];
    assign w_in_item.component       = s_axis_tuser[2];
    assign w_in_item.mv_code         = s_axis_tdata[5:0];
    assign w_in_item.motion_residual = s_axis_tdata[13:6];
    assign w_in_item.halve_vertical  = s_axis_tdata[14];
    assign w_in_item.copy_to_second  = s_axis_tdata[15];

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = w_accept || (r_in_valid && !w_adv);
    assign n_out_valid   = w_adv || (r_out_valid && !m_axis_tready);

    assign w_idx      = {r_in.direction, r_in.vector_sel, r_in.component};
    assign w_copy_idx = {r_in.direction, 1'b1, r_in.component};

    mvr_calc u_calc (
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .i_pred  (r_pred[w_idx]),
        .o_value (w_value)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PRED; i++) begin
                r_pred[i] <= '0;
            end
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < NUM_PRED; i++) begin
                if (w_adv && (PRED_IDX_WIDTH'(i) == w_idx
                              || (r_in.copy_to_second
                                  && PRED_IDX_WIDTH'(i) == w_copy_idx))) begin
                    r_pred[i] <= w_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= w_in_item;
        end
        if (w_adv) begin
            r_out <= w_value;
        end
    end

endmodule
